>>> rtl/core/address_range_access_counters_defines.svh
// Assertion macros for the address range access counters checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ADDRESS_RANGE_ACCESS_COUNTERS_DEFINES_SVH
`define ADDRESS_RANGE_ACCESS_COUNTERS_DEFINES_SVH

// same-cycle implication
`define ARAC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arac check failed");

// next-cycle implication
`define ARAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arac check failed");

`endif

>>> rtl/core/arac_pkg.sv
// Shared types and constants of the address range access counters.
// No dependencies.
`default_nettype none

package arac_pkg;

  localparam int unsigned NCNT     = 9;
  localparam int unsigned MAXW     = 4;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  localparam logic [2:0] GROUP_GLOBAL = 3'd4;
  localparam logic [2:0] NO_MATCH     = 3'd4;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_EXEC  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    CNT_ACC  = 4'd0,
    CNT_RD   = 4'd1,
    CNT_RDB  = 4'd2,
    CNT_WR   = 4'd3,
    CNT_WRB  = 4'd4,
    CNT_EX   = 4'd5,
    CNT_CYC  = 4'd6,
    CNT_HIT  = 4'd7,
    CNT_MISS = 4'd8
  } cnt_e;

  typedef enum logic [2:0] {
    CFG_MONITOR = 3'd0,
    CFG_WIN0    = 3'd1,
    CFG_WIN1    = 3'd2,
    CFG_WIN2    = 3'd3,
    CFG_WIN3    = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> rtl/core/arac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arac_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/address_range_access_counters.sv
// Address range access counters: global and per-window access statistics.
// Requests pass stage 1, then the result register. Throughput: 1 request/cycle while not stalled.
// Window counter rows live in arac_ram; the accept edge reads a row, the next stage adds
// and writes back, with forwarding of the last written row. Uses arac_pkg, arac_ram.
// Reset: counters read as zero, monitoring enabled, all windows disabled.
`default_nettype none

module address_range_access_counters
  import arac_pkg::*;
#(
  parameter int unsigned NUM_WINDOWS   = 4,
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [31:0]         access_address_i,
  input  wire logic [1:0]          access_kind_i,
  input  wire logic [11:0]         access_bytes_i,
  input  wire logic [15:0]         access_cycles_i,
  input  wire logic                cache_hit_i,
  input  wire logic [2:0]          counter_group_i,
  input  wire logic [3:0]          counter_index_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [63:0]         read_data_o,
  output logic      [2:0]          matched_window_o,
  output logic                     status_o,
  // config port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned CntW  = COUNTER_WIDTH;
  localparam int unsigned RowW  = NCNT * CntW;
  localparam int unsigned RowAw = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

  typedef logic [NCNT-1:0][CntW-1:0] row_t;

  function automatic row_t bump_row(row_t row, logic [1:0] kind, logic [11:0] bytes,
                                    logic [15:0] cycles, logic hit);
    row_t r;
    r = row;
    r[CNT_ACC] = r[CNT_ACC] + CntW'(1);
    r[CNT_CYC] = r[CNT_CYC] + CntW'(cycles);
    unique case (kind_e'(kind))
      KIND_READ: begin
        r[CNT_RD]  = r[CNT_RD] + CntW'(1);
        r[CNT_RDB] = r[CNT_RDB] + CntW'(bytes);
      end
      KIND_WRITE: begin
        r[CNT_WR]  = r[CNT_WR] + CntW'(1);
        r[CNT_WRB] = r[CNT_WRB] + CntW'(bytes);
      end
      KIND_EXEC: begin
        r[CNT_EX] = r[CNT_EX] + CntW'(1);
      end
      default: begin
      end
    endcase
    if (hit) begin
      r[CNT_HIT] = r[CNT_HIT] + CntW'(1);
    end else begin
      r[CNT_MISS] = r[CNT_MISS] + CntW'(1);
    end
    return r;
  endfunction

  // ---------------- config registers ----------------
  logic             mon_en_q;
  logic [63:0]      win_q [MAXW];
  logic [32:0]      lim_q [MAXW];
  logic             cfg_wr;
  cfg_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q <= 1'b1;
      for (int w = 0; w < MAXW; w++) begin
        win_q[w] <= '0;
        lim_q[w] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_MONITOR: mon_en_q <= pwdata[0];
        CFG_WIN0: begin
          win_q[0] <= pwdata;
          lim_q[0] <= {1'b0, pwdata[63:32]} + {1'b0, pwdata[31:0]};
        end
        CFG_WIN1: begin
          win_q[1] <= pwdata;
          lim_q[1] <= {1'b0, pwdata[63:32]} + {1'b0, pwdata[31:0]};
        end
        CFG_WIN2: begin
          win_q[2] <= pwdata;
          lim_q[2] <= {1'b0, pwdata[63:32]} + {1'b0, pwdata[31:0]};
        end
        CFG_WIN3: begin
          win_q[3] <= pwdata;
          lim_q[3] <= {1'b0, pwdata[63:32]} + {1'b0, pwdata[31:0]};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_MONITOR: prdata = {{(CfgDataW-1){1'b0}}, mon_en_q};
      CFG_WIN0:    prdata = win_q[0];
      CFG_WIN1:    prdata = win_q[1];
      CFG_WIN2:    prdata = win_q[2];
      CFG_WIN3:    prdata = win_q[3];
      default:     prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic s1_valid_q;
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- stage 0: window match, row read ----------------
  logic [NUM_WINDOWS-1:0] win_hit;
  logic [2:0]             match_w;
  logic [RowAw-1:0]       rd_row;
  logic                   rec_en;

  always_comb begin
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      win_hit[w] = (win_q[w][31:0] != '0) && (access_address_i >= win_q[w][63:32]) &&
                   ({1'b0, access_address_i} < lim_q[w]);
    end
  end

  always_comb begin
    match_w = NO_MATCH;
    for (int w = NUM_WINDOWS - 1; w >= 0; w--) begin
      if (win_hit[w]) begin
        match_w = 3'(w);
      end
    end
  end

  assign rec_en = (op_e'(op_i) == OP_RECORD) && mon_en_q;
  assign rd_row = (op_e'(op_i) == OP_RECORD) ? match_w[RowAw-1:0]
                                              : counter_group_i[RowAw-1:0];

  // ---------------- stage 1 registers ----------------
  op_e              s1_op_q;
  logic             s1_rec_q;
  logic [1:0]       s1_kind_q;
  logic [11:0]      s1_bytes_q;
  logic [15:0]      s1_cycles_q;
  logic             s1_hit_q;
  logic [2:0]       s1_group_q;
  logic [3:0]       s1_index_q;
  logic [2:0]       s1_match_q;
  logic [RowAw-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= op_e'(op_i);
      s1_rec_q    <= rec_en;
      s1_kind_q   <= access_kind_i;
      s1_bytes_q  <= access_bytes_i;
      s1_cycles_q <= access_cycles_i;
      s1_hit_q    <= cache_hit_i;
      s1_group_q  <= counter_group_i;
      s1_index_q  <= counter_index_i;
      s1_match_q  <= rec_en ? match_w : NO_MATCH;
      s1_row_q    <= rd_row;
    end
  end

  // ---------------- counter storage ----------------
  row_t             glob_q;
  logic [NUM_WINDOWS-1:0] vld_q;
  logic             wb_valid_q;
  logic [RowAw-1:0] wb_row_q;
  row_t             wb_data_q;
  logic [RowW-1:0]  ram_rdata;
  row_t             row_cur;
  row_t             win_nxt;
  row_t             glob_nxt;
  logic             win_we;
  logic             do_clear;

  arac_ram #(
    .Width (RowW),
    .Depth (NUM_WINDOWS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (s1_row_q),
    .wdata_i (win_nxt),
    .re_i    (in_acc),
    .raddr_i (rd_row),
    .rdata_o (ram_rdata)
  );

  // forward the row written at the edge where this row was read
  always_comb begin
    if (wb_valid_q && (wb_row_q == s1_row_q)) begin
      row_cur = wb_data_q;
    end else if (vld_q[s1_row_q]) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  assign win_nxt  = bump_row(row_cur, s1_kind_q, s1_bytes_q, s1_cycles_q, s1_hit_q);
  assign glob_nxt = bump_row(glob_q, s1_kind_q, s1_bytes_q, s1_cycles_q, s1_hit_q);
  assign win_we   = s1_adv && s1_rec_q && (s1_match_q != NO_MATCH);
  assign do_clear = s1_adv && (s1_op_q == OP_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glob_q     <= '0;
      vld_q      <= '0;
      wb_valid_q <= 1'b0;
    end else begin
      if (do_clear) begin
        glob_q <= '0;
        vld_q  <= '0;
      end else if (s1_adv && s1_rec_q) begin
        glob_q <= glob_nxt;
      end
      if (win_we) begin
        vld_q[s1_row_q] <= 1'b1;
      end
      if (s1_adv) begin
        wb_valid_q <= win_we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      wb_row_q  <= s1_row_q;
      wb_data_q <= win_nxt;
    end
  end

  // ---------------- read select and result register ----------------
  logic [63:0] rd_data;
  logic        rd_status;

  always_comb begin
    rd_data   = '0;
    rd_status = 1'b0;
    if (s1_op_q == OP_READ) begin
      priority if (s1_index_q >= 4'(NCNT)) begin
        rd_status = 1'b1;
      end else if (s1_group_q == GROUP_GLOBAL) begin
        rd_data = 64'(glob_q[s1_index_q]);
      end else if (32'(s1_group_q) < NUM_WINDOWS) begin
        rd_data = 64'(row_cur[s1_index_q]);
      end else begin
        rd_status = 1'b1;
      end
    end
  end

  logic [63:0] read_data_q;
  logic [2:0]  match_q;
  logic        status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      read_data_q <= rd_data;
      match_q     <= s1_match_q;
      status_q    <= rd_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = read_data_q;
  assign matched_window_o = match_q;
  assign status_o         = status_q;

endmodule

`default_nettype wire

>>> rtl/core/arac_checker.sv
// Port-level checks for address_range_access_counters, bound to the top level.
// Uses arac_pkg and address_range_access_counters_defines.svh.
`default_nettype none

`include "address_range_access_counters_defines.svh"

module arac_checker
  import arac_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] read_data_o,
  input wire logic [2:0]  matched_window_o,
  input wire logic        status_o
);

  logic        out_held;
  logic [67:0] out_bits;
  logic        rec_out;
  logic        err_out;
  logic        data_zero;

  assign out_held  = out_valid_o && out_stall_i;
  assign out_bits  = {read_data_o, matched_window_o, status_o};
  assign rec_out   = out_valid_o && (matched_window_o != NO_MATCH);
  assign err_out   = out_valid_o && status_o;
  assign data_zero = (read_data_o == '0);

  `ARAC_ASSERT_NEXT(out_valid_held, out_held, out_valid_o)
  `ARAC_ASSERT_NEXT(out_data_held, out_held, $stable(out_bits))
  `ARAC_ASSERT_IMPLIES(match_in_range, out_valid_o, matched_window_o <= NO_MATCH)
  `ARAC_ASSERT_IMPLIES(record_result_clean, rec_out, !status_o && data_zero)
  `ARAC_ASSERT_IMPLIES(error_result_clean, err_out, data_zero && (matched_window_o == NO_MATCH))

endmodule

bind address_range_access_counters arac_checker u_arac_checker (.*);

`default_nettype wire
